@@ design/iirdf1_pkg.sv @@
`default_nettype none

package iirdf1_pkg;

    // Field widths of one input word and one result word, the taps register and the accumulator
    localparam int ACTION_W  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int CIDX_W    = 4;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 32;
    localparam int TAPS_W    = 4;
    localparam int ACC_W     = 64;

    localparam int MAX_TAPS_DEF = 11;

    // Configuration port
    localparam int          PADDR_W    = 3;
    localparam int          PDATA_W    = 32;
    localparam int          REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TAPS = '0;
    localparam logic [TAPS_W-1:0]    TAPS_RESET = 4'd11;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_FILTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MB,
        S_MA,
        S_M0,
        S_ACC,
        S_RND
    } t_state;

    // What the registered product does to the accumulator
    typedef enum logic [1:0] {
        PK_NONE,
        PK_ADD,
        PK_SUB
    } t_pk;

    typedef enum logic [1:0] {
        MS_B_X,
        MS_A_Y,
        MS_B_S
    } t_msel;

endpackage

`default_nettype wire

@@ design/iirdf1_ram.sv @@
`default_nettype none

module iirdf1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/iir_direct_form_one_filter_core.sv @@
`default_nettype none

// Channel   Direction  Handshake           Word
// input     in         i_valid / o_ready   i_action, i_sample, i_coef_index, i_coef_value
// output    out        o_valid / i_ready   o_filtered
// config    in         psel, penable, pready (APB write)   paddr, pwdata / prdata
//
// A filter word passes through the read, multiply, accumulate and rounding states
// to the result register, and the next word is taken once the core is idle again;
// the single shared 32x32 multiplier forms one product a cycle, and each tap above
// the first needs two of them.
// Coefficient loads give no result.
// Reset is synchronous and clears the history valid bits, so the history reads as zero.
// A result waiting in the output register does not block the next word; only a
// second result stalls, in the rounding step, until the first is taken.

module iir_direct_form_one_filter_core #(
    parameter int MAX_TAPS = iirdf1_pkg::MAX_TAPS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input words
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic [iirdf1_pkg::ACTION_W-1:0]   i_action,
    input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [iirdf1_pkg::CIDX_W-1:0]     i_coef_index,
    input  wire logic signed [iirdf1_pkg::COEF_W-1:0]   i_coef_value,
    // result words
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic signed [iirdf1_pkg::OUT_W-1:0]    o_filtered,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [iirdf1_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [iirdf1_pkg::PDATA_W-1:0]    pwdata,
    output      logic [iirdf1_pkg::PDATA_W-1:0]    prdata,
    output      logic                              pready
);

    import iirdf1_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = ($clog2(MAX_TAPS + 1) > TAPS_W) ? $clog2(MAX_TAPS + 1) : TAPS_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [TAPS_W-1:0] r_taps;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAPS_RESET;
        end else if (cfg_wr) begin
            r_taps <= pwdata[TAPS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_TAPS) begin
            prdata = PDATA_W'(r_taps);
        end
    end

    // Highest tap index in use: zero taps acts as one, and too many is clamped.
    logic [TW-1:0] taps_ext;
    logic [AW-1:0] start_idx;

    assign taps_ext = TW'(r_taps);

    always_comb begin
        if (taps_ext == '0) begin
            start_idx = '0;
        end else if (taps_ext > TW'(MAX_TAPS)) begin
            start_idx = AW'(MAX_TAPS - 1);
        end else begin
            start_idx = AW'(taps_ext - TW'(1));
        end
    end

    // ---------------------------------------------------------------
    // State and registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    logic [AW-1:0]              r_idx;
    logic [MAX_TAPS-1:0]        r_hvld;
    logic                       r_rd_hv;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [ACC_W-1:0]    r_prod;
    t_pk                        r_pk;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_vld;
    logic signed [OUT_W-1:0]    r_filtered;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic                       b_we, a_we;
    logic [AW-1:0]              c_waddr;
    logic                       c_re;
    logic [AW-1:0]              c_raddr;
    logic [COEF_W-1:0]          b_rdata, a_rdata;
    logic                       h_re;
    logic [AW-1:0]              h_raddr;
    logic                       x_we, y_we;
    logic [AW-1:0]              x_waddr, y_waddr;
    logic [SAMPLE_W-1:0]        x_wdata, x_rdata;
    logic [OUT_W-1:0]           y_wdata, y_rdata;

    iirdf1_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_bcoef (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (c_waddr),
        .i_wdata (i_coef_value),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (b_rdata)
    );

    iirdf1_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_acoef (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (c_waddr),
        .i_wdata (i_coef_value),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (a_rdata)
    );

    iirdf1_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_xhist (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (x_waddr),
        .i_wdata (x_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (x_rdata)
    );

    iirdf1_ram #(.WIDTH(OUT_W), .DEPTH(MAX_TAPS)) u_yhist (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (y_waddr),
        .i_wdata (y_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (y_rdata)
    );

    // History entries never written since reset read as zero.
    logic signed [SAMPLE_W-1:0] x_q;
    logic signed [OUT_W-1:0]    y_q;

    assign x_q = r_rd_hv ? signed'(x_rdata) : '0;
    assign y_q = r_rd_hv ? signed'(y_rdata) : '0;

    // ---------------------------------------------------------------
    // Rounding and saturation of the accumulator
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0] rnd;
    logic signed [OUT_W-1:0] y_sat;

    assign rnd = (r_acc + ACC_W'(8)) >>> 4;

    always_comb begin
        if (rnd > ACC_W'(64'sh7FFF_FFFF)) begin
            y_sat = 32'sh7FFF_FFFF;
        end else if (rnd < -ACC_W'(64'sh8000_0000)) begin
            y_sat = 32'sh8000_0000;
        end else begin
            y_sat = rnd[OUT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic    in_acc;
    logic    is_filter;
    logic    out_free;
    logic    out_load;
    logic    idx_ok;
    t_pk     n_pk;
    t_msel   msel;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign is_filter = (i_action == ACT_FILTER);
    assign out_free  = !r_out_vld || i_ready;
    assign idx_ok    = (TW'(i_coef_index) < TW'(MAX_TAPS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_filter) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = (r_idx == '0) ? S_M0 : S_MB;
            end
            S_MB: begin
                n_state = S_MA;
            end
            S_MA: begin
                n_state = (r_idx == AW'(1)) ? S_M0 : S_MB;
            end
            S_M0: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_RND;
            end
            S_RND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        b_we     = 1'b0;
        a_we     = 1'b0;
        c_waddr  = AW'(i_coef_index);
        c_re     = 1'b0;
        c_raddr  = r_idx;
        h_re     = 1'b0;
        h_raddr  = r_idx - AW'(1);
        x_we     = 1'b0;
        x_waddr  = r_idx;
        x_wdata  = x_q;
        y_we     = 1'b0;
        y_waddr  = r_idx;
        y_wdata  = y_q;
        n_pk     = PK_NONE;
        msel     = MS_B_X;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && idx_ok) begin
                    b_we = (i_action == ACT_LOAD_B);
                    a_we = (i_action == ACT_LOAD_A);
                end
            end
            S_RD: begin
                c_re = 1'b1;
                h_re = (r_idx != '0);
            end
            S_MB: begin
                // Shift one place up: entry idx-1 lands in entry idx.
                x_we = 1'b1;
                y_we = 1'b1;
                n_pk = PK_ADD;
                msel = MS_B_X;
            end
            S_MA: begin
                // Fetch the next lower tap while the feedback product is formed.
                c_re    = 1'b1;
                c_raddr = r_idx - AW'(1);
                h_re    = (r_idx != AW'(1));
                h_raddr = r_idx - AW'(2);
                n_pk    = PK_SUB;
                msel    = MS_A_Y;
            end
            S_M0: begin
                x_we    = 1'b1;
                x_waddr = '0;
                x_wdata = r_sample;
                n_pk    = PK_ADD;
                msel    = MS_B_S;
            end
            S_ACC: begin
                n_pk = PK_NONE;
            end
            S_RND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    y_we     = 1'b1;
                    y_waddr  = '0;
                    y_wdata  = y_sat;
                end
            end
            default: begin
                n_pk = PK_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0] op_a;
    logic signed [OUT_W-1:0]  op_b;
    logic signed [ACC_W-1:0]  mult;

    always_comb begin
        case (msel)
            MS_B_X: begin
                op_a = signed'(b_rdata);
                op_b = OUT_W'(x_q);
            end
            MS_A_Y: begin
                op_a = signed'(a_rdata);
                op_b = y_q;
            end
            MS_B_S: begin
                op_a = signed'(b_rdata);
                op_b = OUT_W'(r_sample);
            end
            default: begin
                op_a = signed'(b_rdata);
                op_b = OUT_W'(x_q);
            end
        endcase
    end

    assign mult = op_a * op_b;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hvld    <= '0;
            r_pk      <= PK_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pk    <= n_pk;
            if (x_we && y_we) begin
                r_hvld[x_waddr] <= 1'b1;
            end
            if (y_we && (r_state == S_RND)) begin
                r_hvld[0] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_filter) begin
            r_sample <= i_sample;
            r_idx    <= start_idx;
            r_acc    <= '0;
        end else begin
            if (r_state == S_MA) begin
                r_idx <= r_idx - AW'(1);
            end
            case (r_pk)
                PK_ADD:  r_acc <= r_acc + r_prod;
                PK_SUB:  r_acc <= r_acc - (r_prod >>> 16);
                default: r_acc <= r_acc;
            endcase
        end
        if (h_re) begin
            r_rd_hv <= r_hvld[h_raddr];
        end
        r_prod <= mult;
        if (out_load) begin
            r_filtered <= y_sat;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_filtered = r_filtered;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_we || a_we) |-> (r_state == S_IDLE))
        else $error("coefficient written while a sample is in progress");

    a_shift_not_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MB) |-> (r_idx != '0))
        else $error("history shift aimed at entry zero");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (TW'(r_idx) < TW'(MAX_TAPS)))
        else $error("tap index beyond the store");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (o_filtered == $past(y_sat))))
        else $error("rounded result not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered)))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

@@ verif/iir_direct_form_one_filter_checker.sv @@
module iir_direct_form_one_filter_checker
    import iirdf1_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [CIDX_W-1:0]          i_coef_index,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    // result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [OUT_W-1:0]    i_filtered,
    // configuration port
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [PADDR_W-1:0]         i_paddr,
    input  logic [PDATA_W-1:0]         i_pwdata,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    logic [TAPS_W-1:0]        taps_in_use;
    logic signed [SAMPLE_W-1:0] sample_line [MAX_TAPS_DEF];
    logic signed [OUT_W-1:0]    output_line [MAX_TAPS_DEF];
    logic signed [COEF_W-1:0]   b_coef      [MAX_TAPS_DEF];
    logic signed [COEF_W-1:0]   a_coef      [MAX_TAPS_DEF];
    logic signed [OUT_W-1:0]    filtered_due [$];
    int                         mismatch_count = 0;

    // Shifts both history lines and forms the saturated Q16.16 output of one sample.
    function automatic logic signed [OUT_W-1:0] run_filter(input logic signed [SAMPLE_W-1:0] x);
        int     n;
        int     i;
        longint acc;
        longint rounded;
        n = int'(taps_in_use);
        if (n > MAX_TAPS_DEF) n = MAX_TAPS_DEF;
        if (n < 1) n = 1;
        acc = 0;
        for (i = n - 1; i > 0; i--) begin
            sample_line[i] = sample_line[i-1];
            output_line[i] = output_line[i-1];
            acc += longint'(b_coef[i]) * longint'(sample_line[i]);
            // The feedback product is Q.36 and is floored down to Q.20.
            acc -= (longint'(a_coef[i]) * longint'(output_line[i])) >>> 16;
        end
        sample_line[0] = x;
        acc += longint'(b_coef[0]) * longint'(x);
        rounded = (acc + 64'sd8) >>> 4;
        if (rounded > 64'sd2147483647)
            output_line[0] = 32'sh7FFF_FFFF;
        else if (rounded < -64'sd2147483648)
            output_line[0] = 32'sh8000_0000;
        else
            output_line[0] = rounded[OUT_W-1:0];
        return output_line[0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (!i_rst_n) begin
            taps_in_use = TAPS_RESET;
            for (int k = 0; k < MAX_TAPS_DEF; k++) begin
                sample_line[k] = '0;
                output_line[k] = '0;
            end
            filtered_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (filtered_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected filtered word, expected none, got %0d",
                             $time, i_filtered);
                end else begin
                    want = filtered_due.pop_front();
                    if (want !== i_filtered) begin
                        mismatch_count++;
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, want, i_filtered);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_action)
                    ACT_FILTER: filtered_due.push_back(run_filter(i_sample));
                    ACT_LOAD_B: begin
                        if (int'(i_coef_index) < MAX_TAPS_DEF) b_coef[i_coef_index] = i_coef_value;
                    end
                    ACT_LOAD_A: begin
                        if (int'(i_coef_index) < MAX_TAPS_DEF) a_coef[i_coef_index] = i_coef_value;
                    end
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[PADDR_W-1:2] == REG_TAPS)
                taps_in_use = i_pwdata[TAPS_W-1:0];
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= filtered_due.size();
    end

endmodule

@@ verif/iir_direct_form_one_filter_core_tb.sv @@
module iir_direct_form_one_filter_core_tb;
    import iirdf1_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
    localparam int                  STUCK_LIMIT = 3000;
    localparam int                  SETTLE_CYCLES = 40;
    localparam int                  WORDS_PER_PHASE = 125;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [ACTION_W-1:0]        i_action;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [CIDX_W-1:0]          i_coef_index;
    logic signed [COEF_W-1:0]   i_coef_value;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [OUT_W-1:0]    o_filtered;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int mismatches;
    int outstanding;
    int stuck_cycles = 0;
    int burst_left   = 0;
    int ready_span   = 0;
    int ready_mode   = 0;

    iir_direct_form_one_filter_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_sample     (i_sample),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_filtered   (o_filtered),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    iir_direct_form_one_filter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_filtered    (o_filtered),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver switches between steady, random, heavily stalled and periodically stalled spells.
    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_span <= $urandom_range(20, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= (ready_span % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic [CIDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] val);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_action     <= act;
        i_sample     <= smp;
        i_coef_index <= idx;
        i_coef_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic filter_word(input logic signed [SAMPLE_W-1:0] smp);
        send_word(ACT_FILTER, smp, CIDX_W'($urandom()), $urandom());
    endtask

    task automatic load_coef(input logic [ACTION_W-1:0] act, input logic [CIDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] val);
        send_word(act, SAMPLE_W'($urandom()), idx, val);
    endtask

    // Called at the edge that took the last word: waits until every result is back.
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_taps(input logic [TAPS_W-1:0] taps);
        logic [PDATA_W-1:0] word;
        word = $urandom();
        word[TAPS_W-1:0] = taps;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TAPS, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3, 4, 5: return SAMPLE_W'($urandom());
            default: return SAMPLE_W'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    // Small coefficients keep the filter mostly stable; the odd full-range one drives
    // it into saturation.
    function automatic logic signed [COEF_W-1:0] pick_coef(input logic [ACTION_W-1:0] act);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel >= 8)
            return $urandom();
        if (sel == 7)
            return (act == ACT_LOAD_B) ? 32'sh0010_0000 : 32'sh0;
        if (act == ACT_LOAD_B)
            return $urandom_range(0, 1 << 19) - (1 << 18);
        return $urandom_range(0, 1 << 18) - (1 << 17);
    endfunction

    task automatic send_random_word(output bit counted);
        int                  sel;
        logic [ACTION_W-1:0] act;
        logic [CIDX_W-1:0]   idx;
        sel = $urandom_range(0, 99);
        counted = 1'b1;
        if (sel < 70) begin
            filter_word(pick_sample());
        end else if (sel < 96) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_LOAD_B : ACT_LOAD_A;
            if ($urandom_range(0, 9) == 0) begin
                idx = CIDX_W'($urandom_range(MAX_TAPS_DEF, 15));
                counted = 1'b0;
            end else begin
                idx = CIDX_W'($urandom_range(0, MAX_TAPS_DEF - 1));
            end
            load_coef(act, idx, pick_coef(act));
        end else begin
            send_word(ACT_UNUSED, SAMPLE_W'($urandom()), CIDX_W'($urandom()), $urandom());
            counted = 1'b0;
        end
    endtask

    initial begin
        logic [TAPS_W-1:0] phase_taps [10];
        bit                counted;
        int                taken;
        phase_taps = '{4'd11, 4'd0, 4'd15, 4'd1, 4'd6, 4'd12, 4'd2, 4'd11, 4'd9, 4'd3};

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_action     <= ACT_FILTER;
        i_sample     <= '0;
        i_coef_index <= '0;
        i_coef_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single tap: saturation at both ends and rounding of halves.
        write_taps(4'd1);
        load_coef(ACT_LOAD_B, 4'd0, 32'sh7FFF_FFFF);
        filter_word(16'sh7FFF);
        filter_word(16'sh8000);
        load_coef(ACT_LOAD_B, 4'd0, 32'sh8000_0000);
        filter_word(16'sh7FFF);
        filter_word(16'sh0000);
        load_coef(ACT_LOAD_B, 4'd15, 32'sh0123_4567);
        send_word(ACT_UNUSED, 16'sh1234, 4'd3, 32'sh7654_3210);
        load_coef(ACT_LOAD_A, 4'd0, 32'sh1234_5678);
        load_coef(ACT_LOAD_B, 4'd0, 32'sh0000_0001);
        filter_word(16'sd8);
        filter_word(-16'sd8);
        filter_word(-16'sd9);
        load_coef(ACT_LOAD_B, 4'd0, 32'sh0010_0000);
        load_coef(ACT_LOAD_B, 4'd1, 32'sh0008_0000);
        load_coef(ACT_LOAD_A, 4'd1, 32'sh0008_0000);
        settle(SETTLE_CYCLES);

        // Two taps, so the feedback path decays the output.
        write_taps(4'd2);
        filter_word(-16'sd1);
        filter_word(16'sd1000);
        filter_word(16'sd0);
        filter_word(16'sd0);
        settle(SETTLE_CYCLES);

        // A taps value of zero behaves as one tap.
        write_taps(4'd0);
        filter_word(16'sd3);
        settle(SETTLE_CYCLES);

        write_taps(4'd11);
        for (int k = 0; k < MAX_TAPS_DEF; k++) begin
            load_coef(ACT_LOAD_B, CIDX_W'(k), pick_coef(ACT_LOAD_B));
            load_coef(ACT_LOAD_A, CIDX_W'(k), pick_coef(ACT_LOAD_A));
        end

        for (int p = 0; p < 10; p++) begin
            settle(SETTLE_CYCLES);
            write_taps(phase_taps[p]);
            taken = 0;
            while (taken < WORDS_PER_PHASE) begin
                send_random_word(counted);
                if (counted) taken++;
                // Let the pipeline drain completely in mid-phase, always in phase 2 and now and then in the others.
                if (taken == WORDS_PER_PHASE / 2 && counted
                        && (p == 2 || $urandom_range(0, 3) == 0))
                    settle(0);
            end
        end

        settle(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/iirdf1_pkg.sv
design/iirdf1_ram.sv
design/iir_direct_form_one_filter_core.sv
verif/iir_direct_form_one_filter_checker.sv
verif/iir_direct_form_one_filter_core_tb.sv
